// ===== rtl/ttcw_pkg.sv =====
// Shared types, codes and limits of the text terminal cell writer.
`default_nettype none
package ttcw_pkg;

	localparam int CELL_CAPACITY_DEF = 4096;
	localparam int BLOCK_SHIFT_DEF   = 4;

	// Wide enough for row * columns + column and for the largest capacity
	localparam int IDX_W = 17;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET    = 6'd25;
	localparam logic [7:0] COLUMNS_MAX   = 8'd128;
	localparam logic [5:0] ROWS_MAX      = 6'd32;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [11:0] read_index;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic       block_dirty;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
	} result_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic sweep_en;
		logic sweep_fill;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/ttcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ttcw_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  wire logic [Width-1:0]                         wdata,
	input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output      logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/ttcw_ctrl.sv =====
// Sequencer: clearing sweep, item accept and result hand-off.
`default_nettype none
module ttcw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic [1:0]        item_kind,
	output      logic              item_stall,
	output      ttcw_pkg::dp_cmd_t cmd,
	input  wire ttcw_pkg::dp_sts_t sts
);

	ttcw_pkg::ctrl_state_t state_q, state_d;
	logic fill_q, fill_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttcw_pkg::ST_SWEEP;
			fill_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		fill_d         = fill_q;
		item_stall     = 1'b1;
		cmd.accept     = 1'b0;
		cmd.sweep_en   = 1'b0;
		cmd.sweep_fill = fill_q;
		cmd.load       = 1'b0;
		case (state_q)
			ttcw_pkg::ST_SWEEP: begin
				cmd.sweep_en = 1'b1;
				if (sts.sweep_last) begin
					// reset pass returns to idle, a clear item still owes its result
					state_d = fill_q ? ttcw_pkg::ST_EXEC : ttcw_pkg::ST_IDLE;
				end
			end
			ttcw_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (item_kind == ttcw_pkg::KIND_CLEAR) begin
						state_d = ttcw_pkg::ST_SWEEP;
						fill_d  = 1'b1;
					end else begin
						state_d = ttcw_pkg::ST_EXEC;
					end
				end
			end
			ttcw_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ttcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttcw_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ttcw_pkg::ST_IDLE))
		else $error("result load did not return to idle");

	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && item_kind == ttcw_pkg::KIND_CLEAR) |=>
		(state_q == ttcw_pkg::ST_SWEEP && fill_q))
		else $error("clear beat did not start a fill sweep");

	a_sweep_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_en |-> (!cmd.accept && !cmd.load && item_stall))
		else $error("sweep overlaps an accept or a load");
`endif

endmodule
`default_nettype wire

// ===== rtl/ttcw_dp.sv =====
// Datapath: cursor, configuration, character and dirty stores, result register.
`default_nettype none
module ttcw_dp #(
	parameter int CellCapacity = ttcw_pkg::CELL_CAPACITY_DEF,
	parameter int BlockShift   = ttcw_pkg::BLOCK_SHIFT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ttcw_pkg::dp_cmd_t cmd,
	output      ttcw_pkg::dp_sts_t sts,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire ttcw_pkg::item_t   item,
	output      logic              result_valid,
	input  wire logic              result_stall,
	output      ttcw_pkg::result_t result
);

	localparam int AW   = $clog2(CellCapacity);
	localparam int NB   = (CellCapacity + (1 << BlockShift) - 1) >> BlockShift;
	localparam int BAW  = (NB > 1) ? $clog2(NB) : 1;
	localparam int IW   = ttcw_pkg::IDX_W;
	localparam logic [IW-1:0] CapIdx  = IW'(CellCapacity);
	localparam logic [AW-1:0] LastIdx = AW'(CellCapacity - 1);

	// configuration
	logic [7:0] cols_q;
	logic [5:0] rows_q;
	logic [7:0] eff_cols;
	logic [5:0] eff_rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ttcw_pkg::COLUMNS_RESET;
			rows_q <= ttcw_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ttcw_pkg::REG_COLUMNS: cols_q <= cfg_data;
				ttcw_pkg::REG_ROWS:    rows_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_q == 8'd0) begin
			eff_cols = 8'd1;
		end else if (cols_q > ttcw_pkg::COLUMNS_MAX) begin
			eff_cols = ttcw_pkg::COLUMNS_MAX;
		end else begin
			eff_cols = cols_q;
		end
		if (rows_q == 6'd0) begin
			eff_rows = 6'd1;
		end else if (rows_q > ttcw_pkg::ROWS_MAX) begin
			eff_rows = ttcw_pkg::ROWS_MAX;
		end else begin
			eff_rows = rows_q;
		end
	end

	// cursor step for a put beat
	logic [6:0] col_q, col_new, wr_col_d;
	logic [4:0] row_q, row_new, wr_row_d, row_adv;
	logic [7:0] col_inc;
	logic [5:0] row_inc;
	logic       wr_en_d;
	logic [7:0] wdata_d;

	always_comb begin
		col_inc  = {1'b0, col_q} + 8'd1;
		row_inc  = {1'b0, row_q} + 6'd1;
		row_adv  = (row_inc >= eff_rows) ? 5'd0 : row_inc[4:0];
		col_new  = col_q;
		row_new  = row_q;
		wr_col_d = col_q;
		wr_row_d = row_q;
		wr_en_d  = 1'b1;
		wdata_d  = item.char_code;
		if (item.char_code == ttcw_pkg::CHAR_BACKSPACE) begin
			if (col_q == 7'd0) begin
				col_new = 7'(eff_cols - 8'd1);
				row_new = (row_q == 5'd0) ? 5'(eff_rows - 6'd1) : row_q - 5'd1;
			end else begin
				col_new = col_q - 7'd1;
			end
			// blank lands on the cell the cursor moved back to
			wr_col_d = col_new;
			wr_row_d = row_new;
			wdata_d  = ttcw_pkg::CHAR_SPACE;
		end else if (item.char_code == ttcw_pkg::CHAR_NEWLINE) begin
			col_new = 7'd0;
			row_new = row_adv;
			wr_en_d = 1'b0;
		end else if (col_inc >= eff_cols) begin
			col_new = 7'd0;
			row_new = row_adv;
		end else begin
			col_new = col_inc[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 7'd0;
			row_q <= 5'd0;
		end else if (cmd.accept) begin
			if (item.kind == ttcw_pkg::KIND_PUT) begin
				col_q <= col_new;
				row_q <= row_new;
			end else if (item.kind == ttcw_pkg::KIND_CLEAR) begin
				col_q <= 7'd0;
				row_q <= 5'd0;
			end
		end
	end

	// beat held for the execute cycle
	logic [1:0]    kind_q;
	logic          wr_en_q;
	logic [7:0]    wdata_q;
	logic [6:0]    wr_col_q;
	logic [4:0]    wr_row_q;
	logic [AW-1:0] rd_idx_q;
	logic          rd_ok_q;
	logic [IW-1:0] rd_wide;
	logic          rd_ok_d;

	assign rd_wide = IW'(item.read_index);
	assign rd_ok_d = rd_wide < CapIdx;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= item.kind;
			wr_en_q  <= wr_en_d;
			wdata_q  <= wdata_d;
			wr_col_q <= wr_col_d;
			wr_row_q <= wr_row_d;
			rd_idx_q <= rd_wide[AW-1:0];
			rd_ok_q  <= rd_ok_d;
		end
	end

	// sweep counter for reset and clear passes
	logic [AW-1:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_en) begin
			sweep_q <= (sweep_q == LastIdx) ? '0 : sweep_q + AW'(1);
		end
	end

	// stores
	logic [IW-1:0] wr_idx;
	logic          wr_ok;
	logic          put_we;
	logic          store_we;
	logic [AW-1:0] char_waddr, char_raddr;
	logic [BAW-1:0] blk_waddr, blk_raddr;
	logic [7:0]    char_wdata, char_rdata;
	logic          dirty_wdata, dirty_rdata;

	assign wr_idx   = IW'(wr_row_q) * IW'(eff_cols) + IW'(wr_col_q);
	assign wr_ok    = wr_idx < CapIdx;
	assign put_we   = cmd.load && (kind_q == ttcw_pkg::KIND_PUT) && wr_en_q && wr_ok;
	assign store_we = cmd.sweep_en || put_we;

	assign char_waddr  = cmd.sweep_en ? sweep_q : wr_idx[AW-1:0];
	assign char_wdata  = cmd.sweep_en ? ttcw_pkg::CHAR_SPACE : wdata_q;
	assign dirty_wdata = cmd.sweep_en ? cmd.sweep_fill : 1'b1;
	assign blk_waddr   = BAW'(char_waddr >> BlockShift);

	// the read launched at accept is repeated while the beat waits
	assign char_raddr = cmd.accept ? rd_wide[AW-1:0] : rd_idx_q;
	assign blk_raddr  = BAW'(char_raddr >> BlockShift);

	ttcw_ram #(
		.Width (8),
		.Depth (CellCapacity)
	) u_char_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (char_waddr),
		.wdata (char_wdata),
		.raddr (char_raddr),
		.rdata (char_rdata)
	);

	ttcw_ram #(
		.Width (1),
		.Depth (NB)
	) u_dirty_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (blk_waddr),
		.wdata (dirty_wdata),
		.raddr (blk_raddr),
		.rdata (dirty_rdata)
	);

	// result register
	ttcw_pkg::result_t res_d, res_q;
	logic              out_valid_q;
	logic              rd_hit;

	assign rd_hit = (kind_q == ttcw_pkg::KIND_READ) && rd_ok_q;

	always_comb begin
		res_d.cell_char   = rd_hit ? char_rdata : 8'd0;
		res_d.block_dirty = rd_hit ? dirty_rdata : 1'b0;
		res_d.cursor_col  = col_q;
		res_d.cursor_row  = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q <= res_d;
		end
	end

	assign result_valid   = out_valid_q;
	assign result         = res_q;
	assign sts.sweep_last = (sweep_q == LastIdx);
	assign sts.out_free   = !out_valid_q || !result_stall;

`ifndef SYNTH
	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && item.kind == ttcw_pkg::KIND_CLEAR) |=> (col_q == 7'd0 && row_q == 5'd0))
		else $error("clear beat left the cursor away from home");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.out_free)
		else $error("result loaded over a stalled beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/text_terminal_cell_writer.sv =====
// Top level of the character-cell text terminal writer.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------
//  item     | in        | item_valid / item_stall    | ttcw_pkg::item_t
//  result   | out       | result_valid / result_stall| ttcw_pkg::result_t
//  config   | in        | cfg_we                     | cfg_index, cfg_data
//
// Put, read and unused-kind beats are accepted, then held in an execute state that waits
// for a free result register, writes a put's cell and loads the result register.
// A clear beat sweeps every cell, one per cycle, then loads its result in the execute state.
// After reset the same sweep blanks the stores with item_stall high;
// configuration writes are taken throughout.
// A stalled result holds the next beat in its execute state until the register frees.
`default_nettype none
module text_terminal_cell_writer #(
	parameter int CELL_CAPACITY = ttcw_pkg::CELL_CAPACITY_DEF,
	parameter int BLOCK_SHIFT   = ttcw_pkg::BLOCK_SHIFT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output      logic              item_stall,
	input  wire ttcw_pkg::item_t   item,
	output      logic              result_valid,
	input  wire logic              result_stall,
	output      ttcw_pkg::result_t result,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [7:0]        cfg_data
);

	ttcw_pkg::dp_cmd_t cmd;
	ttcw_pkg::dp_sts_t sts;

	ttcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_kind  (item.kind),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	ttcw_dp #(
		.CellCapacity (CELL_CAPACITY),
		.BlockShift   (BLOCK_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire
